[design/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, skipped in reset
`define SRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/srq_pkg.sv]
// ---------------------------------------------------------------------------
// srq_pkg
// types and codes for the segment reorder queue
// ---------------------------------------------------------------------------
package srq_pkg;

  localparam logic [1:0] ACT_INSERT    = 2'd0;
  localparam logic [1:0] ACT_REMOVE    = 2'd1;
  localparam logic [1:0] ACT_REMOVE_NA = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EARLY   = 2'd1;
  localparam logic [1:0] ST_EVICTED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_COMPR  = 2'd1;
  localparam logic [1:0] KIND_MULTI  = 2'd2;

  typedef struct packed {
    logic [31:0] sec;
    logic [7:0]  seg;
    logic        fin;
    logic [1:0]  kind;
    logic [63:0] body;
  } rec_t;

endpackage

[design/segment_reorder_queue.sv]
// ---------------------------------------------------------------------------
// segment_reorder_queue
// sorted record queue with per-second completeness tracking
// ---------------------------------------------------------------------------
// channel  | ports                         | direction
// in       | in_valid/in_stall + in_*      | word in
// out      | out_valid/out_stall + out_*   | word out
// cfg      | cfg_we/cfg_data               | start second write
//
// the record memory (one write port, one read port) is walked to shift
// (insert or pop) where the word needs it, and then to check readiness.
// rst_n is synchronous; the memory holds no reset and needs no clearing.
// the result sits in an output register; the next word is taken only once
// the result is gone, so out_stall holds the block.
module segment_reorder_queue
  import srq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_rec_second,
  input  logic [7:0]  in_rec_segment,
  input  logic        in_rec_final,
  input  logic [1:0]  in_rec_kind,
  input  logic [63:0] in_rec_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_out_second,
  output logic [7:0]  out_out_segment,
  output logic        out_out_final,
  output logic [1:0]  out_out_kind,
  output logic [63:0] out_out_payload,
  output logic        out_second_ready,
  output logic [6:0]  out_queued_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;  // walk down from the tail, shifting up
  localparam logic [2:0] S_POP   = 3'd2;  // walk up from the head, shifting down
  localparam logic [2:0] S_CHK   = 3'd3;  // readiness walk
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;  // memory read latency

  rec_t        mem [DEPTH];
  logic [2:0]  state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]  walk_st;
  logic [CW-1:0] fill_r, fill_nxt, idx_r, idx_nxt;
  logic [31:0] start_r, pend_r, pend_nxt;
  rec_t        nr_r, nr_nxt, gone_r, gone_nxt, rd_q;
  logic [1:0]  stat_r, stat_nxt;
  logic [7:0]  expect_r, expect_nxt;
  logic        ready_r, ready_nxt;
  logic        we;
  logic [AW-1:0] wa, ra;
  rec_t        wd;
  logic        rd_fresh_r, rd_fresh_nxt;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // read address for the walk step being fetched, kept in range
  always_comb begin
    walk_st = (state_r == S_WAIT) ? ret_r : state_r;
    ra = idx_r[AW-1:0];
    if (walk_st == S_INS && idx_r != '0) ra = AW'(idx_r - 1'b1);
    // once the head is captured the pop reads one ahead
    if (walk_st == S_POP && ready_r) ra = AW'(idx_r + 1'b1);
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    fill_nxt = fill_r;
    idx_nxt = idx_r;
    pend_nxt = pend_r;
    nr_nxt = nr_r;
    gone_nxt = gone_r;
    stat_nxt = stat_r;
    expect_nxt = expect_r;
    ready_nxt = ready_r;
    rd_fresh_nxt = 1'b0;
    we = 1'b0;
    wa = idx_r[AW-1:0];
    wd = nr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          nr_nxt = '{in_rec_second, in_rec_segment, in_rec_final, in_rec_kind,
                     in_rec_payload};
          gone_nxt = '0;
          stat_nxt = ST_OK;
          if (in_action == ACT_INSERT) begin
            if (in_rec_second < start_r) begin
              stat_nxt = ST_EARLY;
              idx_nxt = '0;
              state_nxt = S_WAIT;
              ret_nxt = S_CHK;
              expect_nxt = '0;
            end else if (fill_r >= CW'(DEPTH)) begin
              stat_nxt = ST_EVICTED;
              pend_nxt = pend_r + 32'd1;
              idx_nxt = '0;
              state_nxt = S_WAIT;
              ret_nxt = S_POP;
            end else begin
              idx_nxt = fill_r;
              state_nxt = S_WAIT;
              ret_nxt = S_INS;
            end
          end else if (in_action == ACT_REMOVE || in_action == ACT_REMOVE_NA) begin
            idx_nxt = '0;
            state_nxt = S_WAIT;
            if (fill_r == '0) begin
              stat_nxt = ST_EMPTY;
              ret_nxt = S_CHK;
              expect_nxt = '0;
            end else begin
              if (in_action == ACT_REMOVE) pend_nxt = pend_r + 32'd1;
              ret_nxt = S_POP;
            end
          end else begin
            idx_nxt = '0;
            state_nxt = S_WAIT;
            ret_nxt = S_CHK;
            expect_nxt = '0;
          end
        end
      end
      S_WAIT: begin
        state_nxt = ret_r;
        rd_fresh_nxt = 1'b1;
      end
      S_INS: begin
        // rd_q holds mem[idx-1] when idx != 0
        if (!rd_fresh_r) begin
          rd_fresh_nxt = 1'b1;
        end else if (idx_r != '0 &&
                     ((nr_r.sec == rd_q.sec) ? (nr_r.seg < rd_q.seg)
                                             : (nr_r.sec < rd_q.sec))) begin
          we = 1'b1;
          wd = rd_q;
          idx_nxt = idx_r - 1'b1;
        end else begin
          we = 1'b1;
          wd = nr_r;
          fill_nxt = fill_r + 1'b1;
          idx_nxt = '0;
          expect_nxt = '0;
          state_nxt = S_WAIT;
          ret_nxt = S_CHK;
        end
      end
      S_POP: begin
        // idx 0 first: rd_q is the head
        if (!rd_fresh_r) begin
          rd_fresh_nxt = 1'b1;
        end else if (idx_r == '0 && !ready_r) begin
          gone_nxt = rd_q;
          ready_nxt = 1'b1;  // marks head captured during the pop
          state_nxt = S_WAIT;
          ret_nxt = S_POP;
        end else if (idx_r + 1'b1 < fill_r) begin
          // rd_q = mem[idx+1]
          we = 1'b1;
          wd = rd_q;
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_WAIT;
        end else begin
          fill_nxt = fill_r - 1'b1;
          ready_nxt = 1'b0;
          idx_nxt = '0;
          expect_nxt = '0;
          state_nxt = S_WAIT;
          ret_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // rd_q = mem[idx]
        if (!rd_fresh_r) begin
          rd_fresh_nxt = 1'b1;
        end else if (idx_r >= fill_r || rd_q.sec != pend_r) begin
          ready_nxt = 1'b0;
          state_nxt = S_OUT;
        end else if (idx_r == '0 &&
                     (rd_q.kind == KIND_SINGLE || rd_q.kind == KIND_COMPR)) begin
          ready_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (rd_q.kind != KIND_MULTI || rd_q.seg != expect_r) begin
          ready_nxt = 1'b0;
          state_nxt = S_OUT;
        end else if (rd_q.fin) begin
          ready_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          expect_nxt = expect_r + 8'd1;
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
          ready_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      fill_r <= '0;
      start_r <= '0;
      pend_r <= '0;
      ready_r <= 1'b0;
      rd_fresh_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
      ready_r <= ready_nxt;
      rd_fresh_r <= rd_fresh_nxt;
      if (cfg_we) begin
        start_r <= cfg_data;
        pend_r <= cfg_data;
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    nr_r <= nr_nxt;
    gone_r <= gone_nxt;
    stat_r <= stat_nxt;
    expect_r <= expect_nxt;
  end

  assign out_status       = stat_r;
  assign out_out_second   = gone_r.sec;
  assign out_out_segment  = gone_r.seg;
  assign out_out_final    = gone_r.fin;
  assign out_out_kind     = gone_r.kind;
  assign out_out_payload  = gone_r.body;
  assign out_second_ready = ready_r;
  assign out_queued_count = 7'(fill_r);

endmodule

[design/srq_checker.sv]
// ---------------------------------------------------------------------------
// srq_checker
// port-level checks for the segment reorder queue
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srq_checker
  import srq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [31:0] out_out_second
);

  // a word is never taken while a result is held
  `SRQ_ASSERT_IMP(a_no_take_busy, clk, rst_n, out_valid, in_stall, "input taken with result held")
  // accepted word blocks the input next cycle
  `SRQ_ASSERT_NEXT(a_busy_after, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")
  // refused or empty results carry no record
  `SRQ_ASSERT_IMP(a_no_rec, clk, rst_n, out_valid && (out_status == ST_EARLY || out_status == ST_EMPTY), out_out_second == 32'd0, "record reported on refusal")

endmodule

bind segment_reorder_queue srq_checker u_srq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_out_second(out_out_second)
);
